/* hw/rtl/lcs_pkg.sv */
package lcs_pkg;
    localparam int WIDTH = 32;
    // signed width for the Bezout coefficients and their products
    localparam int TW = WIDTH + 2;
    localparam int CW = $clog2(WIDTH + 1);

    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] dividend;
        logic [WIDTH-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;
endpackage

/* hw/rtl/lcs_div.sv */
module lcs_div import lcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output t_div_sts         o_sts,
    output logic [WIDTH-1:0] o_quo,
    output logic [WIDTH-1:0] o_rem
);
    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_dvs;
    logic [WIDTH:0]   sh;
    logic [WIDTH:0]   diff;
    logic             ge;

    // restoring radix-2, one quotient bit per cycle
    assign sh   = {r_rem, r_quo[WIDTH-1]};
    assign diff = sh - {1'b0, r_dvs};
    assign ge   = (sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= ge ? diff[WIDTH-1:0] : sh[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;
    assign o_rem      = r_rem;
endmodule

/* hw/rtl/linear_congruence_solver.sv */
// Solves coef * x = rhs (mod modulus) one item at a time. A single shared
// radix-2 divider and a bit-serial multiplier do the arithmetic: each
// extended-Euclid step on (modulus, coef mod modulus) takes one division and
// one WIDTH-bit serial multiply, and the setup and wrap-up add four divisions
// and a WIDTH-bit serial modular multiply.
// o_stall stays high from accept until the result is loaded into the output
// register; the next item is taken while that result still waits.
module linear_congruence_solver import lcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_coef,
    input  logic [WIDTH-1:0] i_rhs,
    input  logic [WIDTH-1:0] i_modulus,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WIDTH-1:0] o_solution,
    output logic             o_solvable
);
    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_CHECK, S_EDIV, S_EMUL, S_EUPD,
        S_DB, S_DM, S_DT, S_MMUL, S_DONE
    } t_state;

    t_state                  r_state;
    logic [WIDTH-1:0]        r_b, r_n;
    logic [WIDTH-1:0]        r_r0, r_r1, r_r2;
    logic signed [TW-1:0]    r_t0, r_t1;
    logic [WIDTH-1:0]        r_q;
    logic [TW-1:0]           r_acc;
    logic [CW-1:0]           r_cnt;
    logic [WIDTH-1:0]        r_bq, r_m, r_inv, r_macc, r_x;
    logic                    r_phase, r_ok;
    logic                    r_ovalid;
    logic [WIDTH-1:0]        r_osol;
    logic                    r_osolv;

    t_div_req                div_req;
    t_div_sts                div_sts;
    logic [WIDTH-1:0]        div_quo, div_rem;

    logic [WIDTH-1:0]        abs_t1, abs_t0;
    logic signed [TW-1:0]    prod, t2;
    logic [WIDTH-1:0]        mm_next;
    logic                    in_acc;

    lcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_sts   (div_sts),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                                 input logic [WIDTH-1:0] y,
                                                 input logic [WIDTH-1:0] m);
        logic [WIDTH-1:0] room;
        room = m - y;
        return (x >= room) ? (x - room) : (x + y);
    endfunction

    assign in_acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    assign abs_t1 = r_t1[TW-1] ? WIDTH'(-r_t1) : r_t1[WIDTH-1:0];
    assign abs_t0 = r_t0[TW-1] ? WIDTH'(-r_t0) : r_t0[WIDTH-1:0];
    assign prod   = r_t1[TW-1] ? -$signed(r_acc) : $signed(r_acc);
    assign t2     = r_t0 - prod;

    always_comb begin
        if (!r_phase) begin
            mm_next = add_mod(r_macc, r_macc, r_m);
        end else if (r_bq[WIDTH-1]) begin
            mm_next = add_mod(r_macc, r_inv, r_m);
        end else begin
            mm_next = r_macc;
        end
    end

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = r_r0;
        div_req.divisor  = r_r1;
        unique case (r_state)
            S_IDLE: begin
                div_req.start    = in_acc && (i_modulus != '0);
                div_req.dividend = i_coef;
                div_req.divisor  = i_modulus;
            end
            S_CHECK: begin
                div_req.start = 1'b1;
                if (r_r1 == '0) begin
                    div_req.dividend = r_b;
                    div_req.divisor  = r_r0;
                end
            end
            S_DB: begin
                div_req.start    = div_sts.done && (div_rem == '0);
                div_req.dividend = r_n;
                div_req.divisor  = r_r0;
            end
            S_DM: begin
                div_req.start    = div_sts.done;
                div_req.dividend = abs_t0;
                div_req.divisor  = div_quo;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (o_valid && !i_stall && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_b <= i_rhs;
                        r_n <= i_modulus;
                        if (i_modulus == '0) begin
                            r_x     <= '0;
                            r_ok    <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    if (div_sts.done) begin
                        r_r0    <= r_n;
                        r_r1    <= div_rem;
                        r_t0    <= '0;
                        r_t1    <= TW'(1);
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= (r_r1 == '0) ? S_DB : S_EDIV;
                end
                S_EDIV: begin
                    if (div_sts.done) begin
                        r_q     <= div_quo;
                        r_r2    <= div_rem;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_EMUL;
                    end
                end
                S_EMUL: begin
                    r_acc <= {r_acc[TW-2:0], 1'b0}
                             + (r_q[WIDTH-1] ? TW'(abs_t1) : TW'(0));
                    r_q   <= {r_q[WIDTH-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(WIDTH - 1)) begin
                        r_state <= S_EUPD;
                    end
                end
                S_EUPD: begin
                    r_r0    <= r_r1;
                    r_r1    <= r_r2;
                    r_t0    <= r_t1;
                    r_t1    <= t2;
                    r_state <= S_CHECK;
                end
                S_DB: begin
                    if (div_sts.done) begin
                        r_bq <= div_quo;
                        if (div_rem != '0) begin
                            r_x     <= '0;
                            r_ok    <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DM;
                        end
                    end
                end
                S_DM: begin
                    if (div_sts.done) begin
                        r_m     <= div_quo;
                        r_state <= S_DT;
                    end
                end
                S_DT: begin
                    if (div_sts.done) begin
                        // negative coefficient: fold into [0, m)
                        r_inv   <= (r_t0[TW-1] && div_rem != '0) ? (r_m - div_rem)
                                                                 : div_rem;
                        r_macc  <= '0;
                        r_phase <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_MMUL;
                    end
                end
                S_MMUL: begin
                    r_macc  <= mm_next;
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        r_bq  <= {r_bq[WIDTH-2:0], 1'b0};
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == CW'(WIDTH - 1)) begin
                            r_x     <= mm_next;
                            r_ok    <= 1'b1;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_osol   <= r_x;
                        r_osolv  <= r_ok;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid    = r_ovalid;
    assign o_solution = r_osol;
    assign o_solvable = r_osolv;

    a_unsolv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_solvable |-> o_solution == '0)
        else $error("unsolvable result with nonzero solution");

    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !div_sts.busy)
        else $error("divider running while idle");

    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("input not stalled after accept");

    a_euclid_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EDIV && div_sts.done |-> r_r1 != '0)
        else $error("Euclid step with zero divisor");
endmodule

/* tb/tb_linear_congruence_solver.sv */
module tb_linear_congruence_solver;
    import lcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [WIDTH-1:0] solution;
        logic             solvable;
    } t_answer;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [WIDTH-1:0] i_coef = '0;
    logic [WIDTH-1:0] i_rhs = '0;
    logic [WIDTH-1:0] i_modulus = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [WIDTH-1:0] o_solution;
    logic             o_solvable;

    t_answer          answer_q[$];
    int               mismatch_cnt = 0;
    longint           cycle_cnt = 0;
    bit               quiet = 1'b0;
    bit               sink_idle = 1'b0;

    localparam longint CYCLE_LIMIT = 3_000_000;

    linear_congruence_solver dut (.*);

    always #4 i_clk = ~i_clk;

    function automatic logic [WIDTH-1:0] gcd_of(logic [WIDTH-1:0] a, logic [WIDTH-1:0] b);
        logic [WIDTH-1:0] r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // modular product at double width
    function automatic logic [WIDTH-1:0] mulmod(logic [WIDTH-1:0] x, logic [WIDTH-1:0] y,
                                                logic [WIDTH-1:0] m);
        logic [2*WIDTH-1:0] p;
        p = {{WIDTH{1'b0}}, x} * {{WIDTH{1'b0}}, y};
        return WIDTH'(p % {{WIDTH{1'b0}}, m});
    endfunction

    function automatic logic [WIDTH-1:0] inverse_of(logic [WIDTH-1:0] a, logic [WIDTH-1:0] m);
        logic [WIDTH-1:0] r0, r1, r2, t0, t1, t2, q, p;
        if (m == 1) return '0;
        r0 = m;
        r1 = a % m;
        t0 = '0;
        t1 = 1;
        while (r1 != 0) begin
            q = r0 / r1;
            r2 = r0 - q * r1;
            p = mulmod(q % m, t1, m);
            t2 = (t0 >= p) ? t0 - p : t0 + (m - p);
            r0 = r1;
            r1 = r2;
            t0 = t1;
            t1 = t2;
        end
        return t0;
    endfunction

    function automatic t_answer solve_congruence(logic [WIDTH-1:0] a, logic [WIDTH-1:0] b,
                                                 logic [WIDTH-1:0] n);
        t_answer          ans;
        logic [WIDTH-1:0] d, m;
        ans = '0;
        if (n == 0) return ans;
        d = gcd_of(a, n);
        if (b % d != 0) return ans;
        m = n / d;
        ans.solution = mulmod((b / d) % m, inverse_of((a / d) % m, m), m);
        ans.solvable = 1'b1;
        return ans;
    endfunction

    task automatic report_mismatch(string what, logic [WIDTH-1:0] got, logic [WIDTH-1:0] exp);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
        mismatch_cnt++;
    endtask

    // valid stays high after the accept until the next item or an idle stretch
    task automatic send_item(logic [WIDTH-1:0] a, logic [WIDTH-1:0] b, logic [WIDTH-1:0] n);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_coef    <= a;
        i_rhs     <= b;
        i_modulus <= n;
        answer_q = {answer_q, solve_congruence(a, b, n)};
        do @(posedge i_clk); while (o_stall);
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("linear_congruence_solver verification failed");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (!quiet && !sink_idle && $urandom_range(0, 9) == 0) begin
                sink_idle = 1'b1;
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_stall <= 1'b0;
                sink_idle = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (answer_q.size() == 0) begin
                report_mismatch("unexpected beat", o_solution, '0);
            end else begin
                t_answer e;
                e = answer_q.pop_front();
                if (o_solution !== e.solution) report_mismatch("solution", o_solution, e.solution);
                if (o_solvable !== e.solvable)
                    report_mismatch("solvable", WIDTH'(o_solvable), WIDTH'(e.solvable));
            end
        end
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (answer_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [WIDTH-1:0] ones;
        ones = '1;
        send_item(0, 0, 1);
        send_item(ones, ones, ones);
        send_item(0, 5, 7);             // zero coef, no solution
        send_item(0, 14, 7);            // zero coef, solvable
        send_item(3, 5, 0);             // zero modulus
        send_item(6, 4, 8);             // gcd divides rhs
        send_item(6, 3, 8);             // gcd does not divide rhs
        send_item(5, 3, 1);             // reduced modulus of one
        send_item(4, 8, 4);
        send_item(ones, 1, ones - 1);
        send_item(32'h8000_0000, 32'h8000_0000, ones);
        send_item(32'hB520_3B7D, 32'h1234_5678, 32'hFFFF_FFFB);
        send_item(32'd1836311903, ones, 32'd2971215073);   // long Euclid chain
        send_item(ones, 0, 32'h8000_0000);
        send_item(2, 1, 32'h8000_0000);
        send_item(7, ones, 3);
    endtask

    task automatic test_pause();
        wait_drained();
        send_item(12, 18, 30);
        wait_drained();
    endtask

    task automatic test_random(int count);
        logic [WIDTH-1:0] a, b, n, g;
        repeat (count) begin
            a = $urandom();
            b = $urandom();
            n = $urandom();
            case ($urandom_range(0, 5))
                0: n = $urandom_range(0, 20);
                1: begin
                    g = $urandom_range(1, 64);
                    a = a / g * g;
                    n = (n / g) * g;
                    if ($urandom_range(0, 1)) b = b / g * g;
                end
                2: a = $urandom_range(0, 3);
                3: b = $urandom_range(0, 3);
                default: ;
            endcase
            send_item(a, b, n);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_pause();
        test_random(95);
        quiet = 1'b1;
        test_random(28);
        wait_drained();
        repeat (4000) @(posedge i_clk);
        if (mismatch_cnt == 0 && answer_q.size() == 0) begin
            $display("linear_congruence_solver verification clean");
        end else begin
            $display("linear_congruence_solver verification failed");
        end
        $finish;
    end
endmodule

/* linear_congruence_solver.f */
hw/rtl/lcs_pkg.sv
hw/rtl/lcs_div.sv
hw/rtl/linear_congruence_solver.sv
tb/tb_linear_congruence_solver.sv
